// File: hdl/otsu_class_variance_engine_top_macros.svh
// otsu_class_variance_engine_top_macros.svh
// assertion macros used by the engine's sequencer; no other dependencies
`ifndef OTSU_CLASS_VARIANCE_ENGINE_TOP_MACROS_SVH
`define OTSU_CLASS_VARIANCE_ENGINE_TOP_MACROS_SVH

// clocked check, muted while reset is asserted
`define OCVE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define OCVE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ocve_pkg.sv
// ocve_pkg.sv
// shared types and constants of the otsu class variance engine; no dependencies
`timescale 1ns / 1ps

package ocve_pkg;

	localparam int BIN_COUNT = 256;
	localparam int BIN_W     = 8;
	localparam int FRAC      = 16;
	localparam int VAL_W     = 16;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BIN_W-1:0]  bin_index;
		logic [VAL_W-1:0]  bin_value;
		logic [BIN_W-1:0]  threshold;
	} item_t;

	typedef struct packed {
		logic [16:0] class1_prob;
		logic [16:0] class2_prob;
		logic [23:0] class1_cum_mean;
		logic [23:0] global_mean;
		logic [31:0] global_variance;
		logic [31:0] between_variance;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic             clear;
		logic             issue;
		logic             pass2;
		logic [BIN_W-1:0] addr;
		logic             fin1;
		logic             div_load;
		logic             div_step;
		logic             capture;
	} cmd_t;

endpackage

// File: hdl/ocve_ram.sv
// ocve_ram.sv
// generic single write, single registered read ram; no dependencies
`timescale 1ns / 1ps

module ocve_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/ocve_ctrl.sv
// ocve_ctrl.sv
// sequencer for histogram sweeps, division and result handoff
// depends on ocve_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "otsu_class_variance_engine_top_macros.svh"

module ocve_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  logic         item_kind,
	output logic         item_stall,
	output logic         result_valid,
	input  logic         result_stall,
	output ocve_pkg::cmd_t cmd
);
	import ocve_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_P1   = 4'd1;
	localparam logic [3:0] S_W1   = 4'd2;
	localparam logic [3:0] S_F1   = 4'd3;
	localparam logic [3:0] S_P2   = 4'd4;
	localparam logic [3:0] S_W2   = 4'd5;
	localparam logic [3:0] S_DL   = 4'd6;
	localparam logic [3:0] S_DV   = 4'd7;
	localparam logic [3:0] S_FN   = 4'd8;

	localparam logic [BIN_W-1:0] LAST_BIN   = BIN_W'(BIN_COUNT - 1);
	localparam logic [BIN_W-1:0] DRAIN_LAST = BIN_W'(3);
	localparam logic [BIN_W-1:0] DIV_LAST   = BIN_W'(31);

	logic [3:0]       state_q;
	logic [BIN_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || !result_stall;

	always_comb begin
		cmd          = '0;
		cmd.addr     = cnt_q;
		unique case (state_q)
			S_IDLE: cmd.clear = item_valid && (item_kind == KIND_QUERY);
			S_P1: cmd.issue = 1'b1;
			S_W1: ;
			S_F1: cmd.fin1 = 1'b1;
			S_P2: begin
				cmd.issue = 1'b1;
				cmd.pass2 = 1'b1;
			end
			S_W2: ;
			S_DL: cmd.div_load = 1'b1;
			S_DV: cmd.div_step = 1'b1;
			S_FN: cmd.capture = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (item_valid && (item_kind == KIND_QUERY)) begin
						state_q <= S_P1;
					end
				end
				S_P1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIN) begin
						state_q <= S_W1;
					end
				end
				S_W1: state_q <= S_F1;
				S_F1: begin
					cnt_q   <= '0;
					state_q <= S_P2;
				end
				S_P2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIN) begin
						state_q <= S_W2;
					end
				end
				S_W2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DRAIN_LAST) begin
						state_q <= S_DL;
					end
				end
				S_DL: begin
					cnt_q   <= '0;
					state_q <= S_DV;
				end
				S_DV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_FN;
					end
				end
				S_FN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`OCVE_ASSERT(a_hold_result, out_valid_q && result_stall |=> out_valid_q, "result dropped under stall")
	`OCVE_ASSERT(a_query_start, (state_q == S_IDLE) && item_valid && item_kind |=> state_q == S_P1, "query did not start sweep")
	`OCVE_ASSERT(a_div_len, (state_q == S_DV) && (cnt_q == DIV_LAST) |=> state_q == S_FN, "divider ran wrong length")
	`OCVE_ASSERT(a_no_capture_busy, cmd.capture |-> !(out_valid_q && result_stall), "result overwritten")

endmodule

// File: hdl/ocve_datapath.sv
// ocve_datapath.sv
// accumulators, variance pipeline and serial divider of the engine
// depends on ocve_pkg
`timescale 1ns / 1ps

module ocve_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ocve_pkg::cmd_t             cmd,
	input  logic [ocve_pkg::BIN_W-1:0] threshold,
	input  logic [ocve_pkg::VAL_W-1:0] rdata,
	output ocve_pkg::result_t          result
);
	import ocve_pkg::*;

	localparam logic [32:0] MEAN_TOP = 33'(255) << FRAC;
	localparam logic [24:0] ONE_FX   = 25'(1) << FRAC;

	logic [BIN_W-1:0] k_q;
	logic [24:0]      p1acc_q;
	logic [32:0]      macc_q, muacc_q;
	logic [16:0]      p1_q, p2_q;
	logic [23:0]      m_q, mu_q;

	logic             issue_s1, pass2_s1, v_s2, v_s3, v_s4;
	logic [BIN_W-1:0] idx_s1;
	logic [23:0]      d_s2;
	logic [VAL_W-1:0] p_s2, p_s3;
	logic [47:0]      d2_s3;
	logic [47:0]      t1_s4;
	logic [15:0]      t2_s4;
	logic [55:0]      vsum_q;

	logic [39:0] prod_q;
	logic [24:0] d16_q;
	logic [49:0] sq_q;
	logic [31:0] den_q;
	logic        bzero_q;

	logic [31:0] rem_q, quo_q, sh_q;
	logic        ovf_q;

	logic [23:0] idx_p;
	logic [23:0] idx_fx;
	logic [39:0] m_fx, dd;
	logic [31:0] lo_p;
	logic [32:0] div_t;
	logic [40:0] var_r;
	logic [31:0] var_sat;

	assign idx_p  = {16'd0, idx_s1} * {8'd0, rdata};
	assign idx_fx = {idx_s1, 16'd0};
	assign m_fx   = {m_q, 16'd0};
	assign dd     = (prod_q >= m_fx) ? prod_q - m_fx : m_fx - prod_q;
	assign lo_p   = d2_s3[15:0] * p_s3;
	assign div_t  = {rem_q, sh_q[31]};
	assign var_r  = 41'((vsum_q + 56'd32768) >> FRAC);
	assign var_sat = (|var_r[40:32]) ? 32'hFFFF_FFFF : var_r[31:0];

	// valid bits of the sweep pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			v_s2     <= issue_s1 && pass2_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= cmd.addr;
		pass2_s1 <= cmd.pass2;

		// first sweep: probability and first moment sums
		if (cmd.clear) begin
			k_q     <= threshold;
			p1acc_q <= '0;
			macc_q  <= '0;
			muacc_q <= '0;
			vsum_q  <= '0;
		end else begin
			if (issue_s1 && !pass2_s1) begin
				muacc_q <= muacc_q + 33'(idx_p);
				if (idx_s1 < k_q) begin
					p1acc_q <= p1acc_q + 25'(rdata);
					macc_q  <= macc_q + 33'(idx_p);
				end
			end
			if (v_s4) begin
				vsum_q <= vsum_q + 56'(t1_s4) + 56'(t2_s4);
			end
		end

		if (cmd.fin1) begin
			p1_q <= (p1acc_q > ONE_FX) ? 17'(ONE_FX) : p1acc_q[16:0];
			p2_q <= (p1acc_q >= ONE_FX) ? 17'd0 : 17'(ONE_FX - p1acc_q);
			m_q  <= (macc_q > MEAN_TOP) ? MEAN_TOP[23:0] : macc_q[23:0];
			mu_q <= (muacc_q > MEAN_TOP) ? MEAN_TOP[23:0] : muacc_q[23:0];
		end

		// second sweep: squared distance weighted by bin
		d_s2  <= (idx_fx >= mu_q) ? idx_fx - mu_q : mu_q - idx_fx;
		p_s2  <= rdata;
		d2_s3 <= d_s2 * d_s2;
		p_s3  <= p_s2;
		t1_s4 <= d2_s3[47:16] * p_s3;
		t2_s4 <= lo_p[31:16];

		// between-class numerator and denominator, settle after fin1
		prod_q  <= p1_q[16] ? {mu_q, 16'd0} : {16'd0, mu_q} * {24'd0, p1_q[15:0]};
		d16_q   <= 25'((dd + 40'd32768) >> FRAC);
		sq_q    <= d16_q * d16_q;
		den_q   <= p1_q[15:0] * p2_q[15:0];
		bzero_q <= (p1_q == '0) || (p2_q == '0);

		// restoring division of sq * 2^16 by den, one quotient bit a cycle
		if (cmd.div_load) begin
			ovf_q <= sq_q[49:16] >= {2'b00, den_q};
			rem_q <= sq_q[47:16];
			sh_q  <= {sq_q[15:0], 16'd0};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			sh_q <= {sh_q[30:0], 1'b0};
			if (div_t >= {1'b0, den_q}) begin
				rem_q <= 32'(div_t - {1'b0, den_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= div_t[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end

		if (cmd.capture) begin
			result.class1_prob     <= p1_q;
			result.class2_prob     <= p2_q;
			result.class1_cum_mean <= m_q;
			result.global_mean     <= mu_q;
			result.global_variance <= var_sat;
			result.between_variance <= bzero_q ? 32'd0 : (ovf_q ? 32'hFFFF_FFFF : quo_q);
		end
	end

endmodule

// File: hdl/otsu_class_variance_engine_top.sv
// otsu_class_variance_engine_top.sv
// top level: histogram ram, sequencer and datapath
// depends on ocve_pkg, ocve_ram, ocve_ctrl, ocve_datapath
`timescale 1ns / 1ps

// Usage
// item channel (item_valid / item_stall / item): a word with kind load writes
// bin_value into bin bin_index; it gives no result.
// a word with kind query starts a statistics run for threshold k.
// result channel (result_valid / result_stall / result) carries one word per query.
// a query runs two sweeps over the 256 bins through the single read port of the
// histogram ram (a wait and a finish state between them, a pipeline drain after
// the second), one divider load, the bit-serial divider and one capture.
// the next word can be accepted in the cycle after capture; no word is taken
// while a query runs, but loads are taken even while a result waits. a stalled
// result is held, and a run that finishes while the previous result is still
// stalled waits before overwriting it.
// reset clears the sequencer and the result valid; histogram contents are
// undefined until each bin is loaded.
module otsu_class_variance_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ocve_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output ocve_pkg::result_t result
);
	import ocve_pkg::*;

	cmd_t             cmd;
	logic [VAL_W-1:0] rdata;
	logic             load_we;

	assign load_we = item_valid && !item_stall && (item.kind == KIND_LOAD);

	ocve_ram #(
		.WIDTH(VAL_W),
		.DEPTH(BIN_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(item.bin_index),
		.wdata(item.bin_value),
		.raddr(cmd.addr),
		.rdata(rdata)
	);

	ocve_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_kind   (item.kind),
		.item_stall  (item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cmd         (cmd)
	);

	ocve_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.threshold(item.threshold),
		.rdata    (rdata),
		.result   (result)
	);

endmodule

// File: sim/otsu_class_variance_engine_top_tb.sv
// otsu_class_variance_engine_top_tb.sv
// self-checking bench for the otsu class variance engine: loads histograms, queries thresholds
// depends on ocve_pkg and otsu_class_variance_engine_top
`timescale 1ns / 1ps

module otsu_class_variance_engine_top_tb;
	import ocve_pkg::*;

	localparam longint ONE_Q   = 64'd1 << FRAC;
	localparam longint HALF_Q  = 64'd1 << (FRAC - 1);
	localparam longint MEAN_TOP = 64'd255 << FRAC;
	localparam longint VAR_TOP = 64'hFFFF_FFFF;
	localparam longint CYCLE_LIMIT = 64'd3_000_000;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	// predictor copy of the histogram
	logic [15:0] hist_model [BIN_COUNT];
	item_t word_queue [$];
	result_t stats_expected [$];
	int mismatches;
	longint cycle_count;
	bit stim_done;
	bit hold_results;
	bit hold_pending;
	int sender_gap;
	int receiver_gap;

	otsu_class_variance_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint diff_abs(longint a, longint b);
		return a >= b ? a - b : b - a;
	endfunction

	function automatic result_t otsu_stats(logic [7:0] thr);
		longint k, p, p1raw, m_raw, mu_raw, p1, p2, m, mu, d, d2, vsum, var_q, bvar;
		longint dd, d16, sq, den, q, r;
		result_t res;
		p1raw = 0; m_raw = 0; mu_raw = 0; vsum = 0; bvar = 0;
		k = thr;
		if (k > BIN_COUNT)
			k = BIN_COUNT;
		for (int i = 0; i < BIN_COUNT; i++) begin
			p = hist_model[i];
			mu_raw += i * p;
			if (i < k) begin
				p1raw += p;
				m_raw += i * p;
			end
		end
		p1 = p1raw > ONE_Q ? ONE_Q : p1raw;
		p2 = p1raw >= ONE_Q ? 0 : ONE_Q - p1raw;
		m = m_raw > MEAN_TOP ? MEAN_TOP : m_raw;
		mu = mu_raw > MEAN_TOP ? MEAN_TOP : mu_raw;
		for (int i = 0; i < BIN_COUNT; i++) begin
			p = hist_model[i];
			d = diff_abs(longint'(i) << FRAC, mu);
			d2 = d * d;
			vsum += (d2 >> FRAC) * p + (((d2 & (ONE_Q - 1)) * p) >> FRAC);
		end
		var_q = (vsum + HALF_Q) >> FRAC;
		if (var_q > VAR_TOP)
			var_q = VAR_TOP;
		// empty class gives zero
		if (p1 != 0 && p2 != 0) begin
			dd = diff_abs(mu * p1, m << FRAC);
			d16 = (dd + HALF_Q) >> FRAC;
			sq = d16 * d16;
			den = p1 * p2;
			q = sq / den;
			r = sq % den;
			if (q >= (64'd1 << (32 - FRAC)))
				bvar = VAR_TOP;
			else begin
				bvar = (q << FRAC) + ((r << FRAC) / den);
				if (bvar > VAR_TOP)
					bvar = VAR_TOP;
			end
		end
		res.class1_prob = p1[16:0];
		res.class2_prob = p2[16:0];
		res.class1_cum_mean = m[23:0];
		res.global_mean = mu[23:0];
		res.global_variance = var_q[31:0];
		res.between_variance = bvar[31:0];
		return res;
	endfunction

	function automatic item_t load_word(int idx, int val);
		item_t w;
		w.kind = KIND_LOAD;
		w.bin_index = idx[7:0];
		w.bin_value = val[15:0];
		w.threshold = 8'($urandom);
		return w;
	endfunction

	function automatic item_t query_word(int thr);
		item_t w;
		w.kind = KIND_QUERY;
		w.bin_index = 8'($urandom);
		w.bin_value = 16'($urandom);
		w.threshold = thr[7:0];
		return w;
	endfunction

	// sender: draws a gap per word, predicts at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			sender_gap <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				if (item.kind == KIND_LOAD)
					hist_model[item.bin_index] = item.bin_value;
				else
					stats_expected.push_back(otsu_stats(item.threshold));
			end
			if (item_valid && item_stall) begin
				// hold the stalled word
			end else if (sender_gap > 0) begin
				item_valid <= 1'b0;
				sender_gap <= sender_gap - 1;
			end else if (hold_pending && (stats_expected.size() != 0
					|| (item_valid && item.kind == KIND_QUERY))) begin
				item_valid <= 1'b0;
			end else if (word_queue.size() != 0) begin
				item <= word_queue.pop_front();
				item_valid <= 1'b1;
				sender_gap <= (word_queue.size() > 3 && $urandom_range(0, 4) == 0) ?
					0 : $urandom_range(0, 4);
			end else
				item_valid <= 1'b0;
		end
	end

	// receiver stall and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			receiver_gap <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (stats_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", result);
				end else begin
					result_t want;
					want = stats_expected.pop_front();
					if (want !== result) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: p1 %h/%h p2 %h/%h m %h/%h mu %h/%h var %h/%h bvar %h/%h",
								want.class1_prob, result.class1_prob,
								want.class2_prob, result.class2_prob,
								want.class1_cum_mean, result.class1_cum_mean,
								want.global_mean, result.global_mean,
								want.global_variance, result.global_variance,
								want.between_variance, result.between_variance);
					end
				end
				receiver_gap <= $urandom_range(0, 4);
			end
			if (hold_results)
				result_stall <= 1'b1;
			else if (receiver_gap > 0) begin
				result_stall <= 1'b1;
				receiver_gap <= receiver_gap - 1;
			end else
				result_stall <= 1'b0;
		end
	end

	// long receiver hold-off, counted in cycles, early in the random part
	initial begin
		hold_results = 1'b0;
		wait (cycle_count > 20000);
		hold_results = 1'b1;
		repeat (3000) @(posedge clk);
		hold_results = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[otsu_class_variance_engine_top] ERROR");
			$finish;
		end
	end

	task automatic fill_histogram(int shape);
		int v;
		for (int i = 0; i < BIN_COUNT; i++) begin
			case (shape)
				0: v = 256;                        // uniform, sums to one
				1: v = (i == 0) ? 65535 : 0;
				2: v = (i == 255) ? 65535 : 0;
				3: v = 65535;                      // far above one
				default: v = (i % 4 == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
			endcase
			word_queue.push_back(load_word(i, v));
		end
	endtask

	initial begin
		mismatches = 0;
		cycle_count = 0;
		stim_done = 1'b0;
		hold_pending = 1'b0;
		arst_n = 1'b0;
		for (int i = 0; i < BIN_COUNT; i++)
			hist_model[i] = '0;
		// directed: all bins written before any query
		fill_histogram(0);
		word_queue.push_back(query_word(0));
		word_queue.push_back(query_word(128));
		word_queue.push_back(query_word(255));
		fill_histogram(1);
		word_queue.push_back(query_word(0));
		word_queue.push_back(query_word(1));
		word_queue.push_back(query_word(255));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// random: loads to random bins mixed with queries
		for (int n = 0; n < 130; n++) begin
			int r;
			r = $urandom_range(0, 9);
			if (n == 60) begin
				wait (word_queue.size() == 0);
				hold_pending = 1'b1;
				wait (stats_expected.size() == 0 && !item_valid);
				hold_pending = 1'b0;
			end
			if (r < 6)
				word_queue.push_back(load_word($urandom_range(0, 255),
					(r == 0) ? 65535 : $urandom_range(0, 4095)));
			else
				word_queue.push_back(query_word($urandom_range(0, 255)));
		end
		wait (word_queue.size() == 0 && !item_valid);
		wait (stats_expected.size() == 0);
		repeat (1200) @(posedge clk);
		if (mismatches == 0 && stats_expected.size() == 0)
			$display("[otsu_class_variance_engine_top] OK");
		else
			$display("[otsu_class_variance_engine_top] ERROR");
		$finish;
	end

endmodule
